>>> hw/rtl/mgse_pkg.sv
// Shared package for the monochrome glyph span expander.
// Holds widths, register codes, reset values, queue entry and status types.
// Used by the interfaces and by every module of the block.
package mgse_pkg;

  localparam int ADDR_BITS   = 22;
  localparam int MAX_SCALE   = 8;
  localparam int SPAN_ADDR_W = 22;
  localparam int COLOR_W     = 32;
  localparam int SCALE_W     = 4;
  localparam int PITCH_W     = 12;
  localparam int SIZE_W      = 6;
  localparam int X_W         = 11;
  localparam int ROW_W       = 6;
  localparam int COL_W       = 3;
  localparam int PAT_W       = 8;
  localparam int LINE_W      = 12;
  localparam int PX_W        = 12;
  localparam int SUB_W       = 3;
  localparam int BIT_W       = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [COLOR_W-1:0] FG_RESET    = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] BG_RESET    = 32'h0000_0000;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd1;
  localparam logic [PITCH_W-1:0] PITCH_RESET = 12'd1024;
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 6'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FG_COLOR    = 3'd0,
    REG_BG_COLOR    = 3'd1,
    REG_OPAQUE_MODE = 3'd2,
    REG_SCALE       = 3'd3,
    REG_LINE_PITCH  = 3'd4,
    REG_GLYPH_SIZE  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic               opaque_mode;
    logic [SCALE_W-1:0] scale;
    logic [PITCH_W-1:0] line_pitch;
    logic [SIZE_W-1:0]  glyph_size;
  } mgse_cfg_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [PAT_W-1:0]     pattern;
  } mgse_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mgse_qstat_t;

  function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] raw);
    logic [SCALE_W-1:0] s;
    if (raw == '0) begin
      s = SCALE_W'(1);
    end else if (raw > SCALE_W'(MAX_SCALE)) begin
      s = SCALE_W'(MAX_SCALE);
    end else begin
      s = raw;
    end
    return s;
  endfunction

endpackage

>>> hw/rtl/mgse_if.sv
// Valid/ready channel interfaces for glyph bytes in and spans out.
// Depends on mgse_pkg for field widths.
interface mgse_in_if;
  logic                            valid;
  logic                            ready;
  logic [mgse_pkg::X_W-1:0]        glyph_x;
  logic [mgse_pkg::X_W-1:0]        glyph_y;
  logic [mgse_pkg::ROW_W-1:0]      glyph_row;
  logic [mgse_pkg::COL_W-1:0]      byte_column;
  logic [mgse_pkg::PAT_W-1:0]      pattern;

  modport source (output valid, glyph_x, glyph_y, glyph_row, byte_column, pattern,
                  input ready);
  modport sink (input valid, glyph_x, glyph_y, glyph_row, byte_column, pattern,
                output ready);
endinterface

interface mgse_out_if;
  logic                              valid;
  logic                              ready;
  logic [mgse_pkg::SPAN_ADDR_W-1:0]  span_address;
  logic [mgse_pkg::SCALE_W-1:0]      span_length;
  logic [mgse_pkg::COLOR_W-1:0]      pixel_color;
  logic                              last;

  modport source (output valid, span_address, span_length, pixel_color, last,
                  input ready);
  modport sink (input valid, span_address, span_length, pixel_color, last,
                output ready);
endinterface

>>> hw/rtl/mono_glyph_span_expander_unit.sv
// Top level of the monochrome glyph span expander: configuration registers,
// front end, queue and span generator. Depends on mgse_pkg and mgse_if.
//
// Each accepted pattern byte yields n * scale span writes, n being the set bits
// of the byte (all eight in opaque mode), emitted at one span per cycle by the
// span generator while the output is not stalled. The front end takes a new byte
// every cycle while the queue has room and computes the span address in registered
// stages; a four-entry queue lets it run ahead of the generator.
// Bytes outside the glyph, or empty bytes in transparent mode, are dropped.
module mono_glyph_span_expander_unit (
  input  logic                              clk,
  input  logic                              rst,
  mgse_in_if.sink                           glyph_in,
  mgse_out_if.source                        span_out,
  input  logic                              cfg_write,
  input  logic [mgse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mgse_pkg::CFG_DATA_W-1:0]   cfg_data
);

  mgse_pkg::mgse_cfg_t   cfg;
  mgse_pkg::mgse_entry_t push_entry;
  mgse_pkg::mgse_entry_t head;
  mgse_pkg::mgse_qstat_t qstat;
  logic                  push;
  logic                  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg_color    <= mgse_pkg::FG_RESET;
      cfg.bg_color    <= mgse_pkg::BG_RESET;
      cfg.opaque_mode <= 1'b0;
      cfg.scale       <= mgse_pkg::SCALE_RESET;
      cfg.line_pitch  <= mgse_pkg::PITCH_RESET;
      cfg.glyph_size  <= mgse_pkg::SIZE_RESET;
    end else if (cfg_write) begin
      unique case (mgse_pkg::cfg_reg_t'(cfg_index))
        mgse_pkg::REG_FG_COLOR:    cfg.fg_color    <= cfg_data;
        mgse_pkg::REG_BG_COLOR:    cfg.bg_color    <= cfg_data;
        mgse_pkg::REG_OPAQUE_MODE: cfg.opaque_mode <= cfg_data[0];
        mgse_pkg::REG_SCALE:       cfg.scale       <= cfg_data[mgse_pkg::SCALE_W-1:0];
        mgse_pkg::REG_LINE_PITCH:  cfg.line_pitch  <= cfg_data[mgse_pkg::PITCH_W-1:0];
        mgse_pkg::REG_GLYPH_SIZE:  cfg.glyph_size  <= cfg_data[mgse_pkg::SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mgse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .glyph_in   (glyph_in),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  mgse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  mgse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .span_out (span_out)
  );

endmodule

>>> hw/rtl/mgse_front.sv
// Front end: accepts glyph bytes, drops out-of-glyph items and empty items in
// transparent mode, and computes the base span address in two pipeline stages. Uses mgse_pkg.
module mgse_front (
  input  logic                  clk,
  input  logic                  rst,
  input  mgse_pkg::mgse_cfg_t   cfg,
  mgse_in_if.sink               glyph_in,
  input  mgse_pkg::mgse_qstat_t qstat,
  output logic                  push,
  output mgse_pkg::mgse_entry_t push_entry
);

  logic [mgse_pkg::SCALE_W-1:0] s;
  logic                         item_ok;
  logic [9:0]                   row_off;
  logic [6:0]                   col_off;
  logic [mgse_pkg::LINE_W-1:0]  line_calc;
  logic [mgse_pkg::PX_W-1:0]    px_calc;
  logic [23:0]                  prod;
  logic                         adv_a;
  logic                         adv_b;

  logic                         a_valid;
  logic [mgse_pkg::LINE_W-1:0]  a_line;
  logic [mgse_pkg::PX_W-1:0]    a_px;
  logic [mgse_pkg::PAT_W-1:0]   a_pattern;
  logic                         b_valid;
  mgse_pkg::mgse_entry_t        b_entry;

  always_comb begin
    s         = mgse_pkg::eff_scale(cfg.scale);
    item_ok   = (glyph_in.glyph_row < cfg.glyph_size) &&
                (glyph_in.byte_column < cfg.glyph_size[5:3]) &&
                ((glyph_in.pattern != '0) || cfg.opaque_mode);
    row_off   = 10'(glyph_in.glyph_row) * 10'(s);
    col_off   = 7'(glyph_in.byte_column) * 7'(s);
    line_calc = mgse_pkg::LINE_W'(glyph_in.glyph_y) + mgse_pkg::LINE_W'(row_off);
    px_calc   = mgse_pkg::PX_W'(glyph_in.glyph_x) + {2'b00, col_off, 3'b000};
    prod      = 24'(a_line) * 24'(cfg.line_pitch);
    adv_b     = !b_valid || !qstat.full;
    adv_a     = !a_valid || adv_b;
  end

  assign glyph_in.ready = adv_a;
  assign push           = b_valid && !qstat.full;
  assign push_entry     = b_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid <= glyph_in.valid && item_ok;
      end
      if (adv_b) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_line    <= line_calc;
      a_px      <= px_calc;
      a_pattern <= glyph_in.pattern;
    end
    if (adv_b) begin
      b_entry.base    <= mgse_pkg::ADDR_BITS'(prod) + mgse_pkg::ADDR_BITS'(a_px);
      b_entry.pattern <= a_pattern;
    end
  end

endmodule

>>> hw/rtl/mgse_queue.sv
// Four-entry queue between the front end and the span generator.
// Depends on mgse_pkg for the entry and status types.
module mgse_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mgse_pkg::mgse_entry_t push_entry,
  input  logic                  pop,
  output mgse_pkg::mgse_entry_t head,
  output mgse_pkg::mgse_qstat_t qstat
);

  mgse_pkg::mgse_entry_t              slots [mgse_pkg::QUEUE_DEPTH];
  logic [mgse_pkg::QPTR_W-1:0]        wr_ptr;
  logic [mgse_pkg::QPTR_W-1:0]        rd_ptr;
  logic [mgse_pkg::QCNT_W-1:0]        count;

  assign head        = slots[rd_ptr];
  assign qstat.full  = (count == mgse_pkg::QCNT_W'(mgse_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

>>> hw/rtl/mgse_back.sv
// Span generator: walks the drawn bits of each queued byte and its sub-rows,
// one span per cycle into an output register while the output is not stalled. Depends on mgse_pkg.
module mgse_back (
  input  logic                  clk,
  input  logic                  rst,
  input  mgse_pkg::mgse_cfg_t   cfg,
  input  mgse_pkg::mgse_entry_t head,
  input  mgse_pkg::mgse_qstat_t qstat,
  output logic                  pop,
  mgse_out_if.source            span_out
);

  logic [mgse_pkg::SCALE_W-1:0]   s;
  logic [mgse_pkg::PAT_W-1:0]     cur_mask;
  logic [mgse_pkg::PAT_W-1:0]     head_mask;
  logic                           more;
  logic [mgse_pkg::BIT_W-1:0]     nb;
  logic [mgse_pkg::BIT_W-1:0]     fb;
  logic [6:0]                     nb_off;
  logic [6:0]                     fb_off;
  logic                           r_last;
  logic                           out_free;
  logic                           emit;
  logic                           last_span;
  logic                           finish;
  logic                           load;

  logic                           active;
  logic [mgse_pkg::ADDR_BITS-1:0] base;
  logic [mgse_pkg::PAT_W-1:0]     pattern;
  logic [mgse_pkg::BIT_W-1:0]     bit_idx;
  logic [mgse_pkg::SUB_W-1:0]     r;
  logic [mgse_pkg::ADDR_BITS-1:0] cur_addr;

  logic                           out_valid;
  logic [mgse_pkg::ADDR_BITS-1:0] out_addr;
  logic [mgse_pkg::SCALE_W-1:0]   out_len;
  logic [mgse_pkg::COLOR_W-1:0]   out_color;
  logic                           out_last;

  // Masks are indexed by drawing position, position zero being the pattern MSB.
  always_comb begin
    s      = mgse_pkg::eff_scale(cfg.scale);
    more   = 1'b0;
    nb     = '0;
    fb     = '0;
    for (int i = 0; i < mgse_pkg::PAT_W; i++) begin
      cur_mask[i]  = pattern[mgse_pkg::PAT_W-1-i] | cfg.opaque_mode;
      head_mask[i] = head.pattern[mgse_pkg::PAT_W-1-i] | cfg.opaque_mode;
    end
    for (int i = mgse_pkg::PAT_W - 1; i >= 0; i--) begin
      if (cur_mask[i] && (mgse_pkg::BIT_W'(i) > bit_idx)) begin
        more = 1'b1;
        nb   = mgse_pkg::BIT_W'(i);
      end
      if (head_mask[i]) begin
        fb = mgse_pkg::BIT_W'(i);
      end
    end
    nb_off    = 7'(nb) * 7'(s);
    fb_off    = 7'(fb) * 7'(s);
    r_last    = ({1'b0, r} == (s - 1'b1));
    out_free  = !out_valid || span_out.ready;
    emit      = active && out_free;
    last_span = r_last && !more;
    finish    = emit && last_span;
    load      = (!active || finish) && !qstat.empty;
  end

  assign pop                   = load;
  assign span_out.valid        = out_valid;
  assign span_out.span_address = mgse_pkg::SPAN_ADDR_W'(out_addr);
  assign span_out.span_length  = out_len;
  assign span_out.pixel_color  = out_color;
  assign span_out.last         = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= emit;
      end
      if (load) begin
        active <= 1'b1;
      end else if (finish) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_addr  <= cur_addr;
      out_len   <= s;
      out_color <= pattern[3'd7 - bit_idx] ? cfg.fg_color : cfg.bg_color;
      out_last  <= last_span;
    end
    if (load) begin
      base     <= head.base;
      pattern  <= head.pattern;
      bit_idx  <= fb;
      r        <= '0;
      cur_addr <= head.base + mgse_pkg::ADDR_BITS'(fb_off);
    end else if (emit && !r_last) begin
      r        <= r + 1'b1;
      cur_addr <= cur_addr + mgse_pkg::ADDR_BITS'(cfg.line_pitch);
    end else if (emit && more) begin
      bit_idx  <= nb;
      r        <= '0;
      cur_addr <= base + mgse_pkg::ADDR_BITS'(nb_off);
    end
  end

  a_sub_row_in_range: assert property (@(posedge clk) disable iff (rst)
    active |-> ({1'b0, r} < s))
    else $error("sub-row counter beyond scale");

  a_bit_is_drawn: assert property (@(posedge clk) disable iff (rst)
    active |-> cur_mask[bit_idx])
    else $error("span generator sits on a bit that draws nothing");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (finish && qstat.empty) |=> !active)
    else $error("span generator still active after the final span");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (emit && last_span) |-> r_last)
    else $error("final span flagged before the last sub-row");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for mono_glyph_span_expander_unit: directed and random glyph bytes,
// predicted span writes compared in order. Depends on mgse_pkg, mgse_if and the RTL top.
module testbench;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_MAX    = 20;

  typedef struct packed {
    logic [mgse_pkg::SPAN_ADDR_W-1:0] addr;
    logic [mgse_pkg::SCALE_W-1:0]     len;
    logic [mgse_pkg::COLOR_W-1:0]     color;
    logic                             last;
  } span_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [mgse_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mgse_pkg::CFG_DATA_W-1:0] cfg_data;

  mgse_in_if  glyph_in ();
  mgse_out_if span_out ();

  mono_glyph_span_expander_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .glyph_in  (glyph_in),
    .span_out  (span_out),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register image used for prediction.
  logic [mgse_pkg::COLOR_W-1:0] sh_fg;
  logic [mgse_pkg::COLOR_W-1:0] sh_bg;
  logic                         sh_opaque;
  logic [mgse_pkg::SCALE_W-1:0] sh_scale;
  logic [mgse_pkg::PITCH_W-1:0] sh_pitch;
  logic [mgse_pkg::SIZE_W-1:0]  sh_size;

  span_t pending_spans[$];
  int    error_count = 0;
  int    bytes_sent = 0;
  int    spans_seen = 0;
  int    settings_used = 0;
  int    cycle_count = 0;
  int    stall_left = 0;
  logic  quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    error_count++;
    if (error_count <= REPORT_MAX) begin
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  function automatic int expand_glyph_byte(input logic [mgse_pkg::X_W-1:0] gx,
                                           input logic [mgse_pkg::X_W-1:0] gy,
                                           input logic [mgse_pkg::ROW_W-1:0] row,
                                           input logic [mgse_pkg::COL_W-1:0] col,
                                           input logic [mgse_pkg::PAT_W-1:0] pat);
    longint unsigned s;
    longint unsigned line;
    longint unsigned px;
    longint unsigned addr;
    logic [mgse_pkg::COLOR_W-1:0] color;
    span_t sp;
    int drawn;
    int n;
    int idx;
    if (sh_scale == 0) s = 64'(1);
    else if (sh_scale > mgse_pkg::MAX_SCALE) s = 64'(mgse_pkg::MAX_SCALE);
    else s = 64'(sh_scale);
    if (row >= sh_size) return 0;
    if (col >= sh_size / 8) return 0;
    drawn = 0;
    for (int b = 0; b < 8; b++) begin
      if (pat[7-b] || sh_opaque) drawn++;
    end
    n = drawn * int'(s);
    idx = 0;
    for (int b = 0; b < 8; b++) begin
      if (pat[7-b]) color = sh_fg;
      else if (sh_opaque) color = sh_bg;
      else continue;
      for (longint unsigned r = 0; r < s; r++) begin
        line = longint'(gy) + longint'(row) * s + r;
        px = longint'(gx) + longint'(col) * 8 * s + longint'(b) * s;
        addr = line * longint'(sh_pitch) + px;
        sp.addr = addr[mgse_pkg::SPAN_ADDR_W-1:0];
        sp.len = s[mgse_pkg::SCALE_W-1:0];
        sp.color = color;
        sp.last = (idx == n - 1);
        pending_spans.push_back(sp);
        idx++;
      end
    end
    return n;
  endfunction

  task automatic send_glyph(input logic [mgse_pkg::X_W-1:0] gx,
                            input logic [mgse_pkg::X_W-1:0] gy,
                            input logic [mgse_pkg::ROW_W-1:0] row,
                            input logic [mgse_pkg::COL_W-1:0] col,
                            input logic [mgse_pkg::PAT_W-1:0] pat, output int produced);
    glyph_in.valid <= 1'b1;
    glyph_in.glyph_x <= gx;
    glyph_in.glyph_y <= gy;
    glyph_in.glyph_row <= row;
    glyph_in.byte_column <= col;
    glyph_in.pattern <= pat;
    do @(posedge clk); while (!glyph_in.ready);
    produced = expand_glyph_byte(gx, gy, row, col, pat);
    bytes_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      glyph_in.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic settle();
    glyph_in.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [mgse_pkg::COLOR_W-1:0] fg,
                            input logic [mgse_pkg::COLOR_W-1:0] bg,
                            input logic op, input logic [mgse_pkg::SCALE_W-1:0] sc,
                            input logic [mgse_pkg::PITCH_W-1:0] pitch,
                            input logic [mgse_pkg::SIZE_W-1:0] size);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= mgse_pkg::REG_FG_COLOR;
    cfg_data <= fg;
    @(posedge clk);
    cfg_index <= mgse_pkg::REG_BG_COLOR;
    cfg_data <= bg;
    @(posedge clk);
    cfg_index <= mgse_pkg::REG_OPAQUE_MODE;
    cfg_data <= mgse_pkg::CFG_DATA_W'(op);
    @(posedge clk);
    cfg_index <= mgse_pkg::REG_SCALE;
    cfg_data <= mgse_pkg::CFG_DATA_W'(sc);
    @(posedge clk);
    cfg_index <= mgse_pkg::REG_LINE_PITCH;
    cfg_data <= mgse_pkg::CFG_DATA_W'(pitch);
    @(posedge clk);
    cfg_index <= mgse_pkg::REG_GLYPH_SIZE;
    cfg_data <= mgse_pkg::CFG_DATA_W'(size);
    @(posedge clk);
    cfg_write <= 1'b0;
    sh_fg = fg;
    sh_bg = bg;
    sh_opaque = op;
    sh_scale = sc;
    sh_pitch = pitch;
    sh_size = size;
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    int n;
    send_glyph(11'd0, 11'd0, 6'd0, 3'd0, 8'h80, n);
    send_glyph(11'd2047, 11'd2047, 6'd15, 3'd1, 8'hFF, n);
    send_glyph(11'd5, 11'd9, 6'd3, 3'd0, 8'h00, n);
    send_glyph(11'd100, 11'd200, 6'd7, 3'd1, 8'h01, n);
    send_glyph(11'd0, 11'd0, 6'd0, 3'd0, 8'h5A, n);
  endtask

  task automatic test_field_extremes();
    int n;
    set_config(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 4'd8, 12'd2048, 6'd48);
    send_glyph(11'd2047, 11'd2047, 6'd47, 3'd5, 8'h00, n);
    send_glyph(11'd0, 11'd0, 6'd0, 3'd0, 8'hFF, n);
    send_glyph(11'd2047, 11'd0, 6'd0, 3'd5, 8'hA5, n);
    set_config($urandom, 32'h0000_0000, 1'b0, 4'd1, 12'd1, 6'd8);
    send_glyph(11'd2047, 11'd2047, 6'd7, 3'd0, 8'h3C, n);
    send_glyph(11'd0, 11'd0, 6'd8, 3'd0, 8'hFF, n);
    send_glyph(11'd0, 11'd0, 6'd0, 3'd1, 8'hFF, n);
  endtask

  task automatic test_out_of_glyph();
    int n;
    set_config(32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 4'd1, 12'd640, 6'd7);
    send_glyph(11'd0, 11'd0, 6'd0, 3'd0, 8'hFF, n);
    set_config(32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 4'd1, 12'd640, 6'd48);
    send_glyph(11'd10, 11'd10, 6'd48, 3'd0, 8'hFF, n);
    send_glyph(11'd10, 11'd10, 6'd63, 3'd7, 8'hFF, n);
    send_glyph(11'd10, 11'd10, 6'd0, 3'd6, 8'hFF, n);
    set_config(32'hCAFE_0001, 32'h0BAD_0002, 1'b0, 4'd2, 12'd800, 6'd63);
    send_glyph(11'd1000, 11'd500, 6'd62, 3'd6, 8'hC3, n);
    send_glyph(11'd1000, 11'd500, 6'd63, 3'd0, 8'hC3, n);
  endtask

  task automatic test_odd_settings();
    int n;
    set_config(32'hFF00_FF00, 32'h00FF_00FF, 1'b1, 4'd0, 12'd0, 6'd16);
    send_glyph(11'd2047, 11'd2047, 6'd15, 3'd1, 8'h96, n);
    send_glyph(11'd3, 11'd4, 6'd1, 3'd0, 8'h69, n);
    set_config(32'h8000_0001, 32'h7FFF_FFFE, 1'b0, 4'd15, 12'd4095, 6'd16);
    send_glyph(11'd2047, 11'd2047, 6'd15, 3'd1, 8'hF0, n);
    send_glyph(11'd1024, 11'd1024, 6'd8, 3'd0, 8'h0F, n);
  endtask

  task automatic send_random_glyph(output int produced);
    logic [mgse_pkg::X_W-1:0] gx;
    logic [mgse_pkg::X_W-1:0] gy;
    logic [mgse_pkg::ROW_W-1:0] row;
    logic [mgse_pkg::COL_W-1:0] col;
    logic [mgse_pkg::PAT_W-1:0] pat;
    gx = mgse_pkg::X_W'($urandom);
    gy = mgse_pkg::X_W'($urandom);
    if ($urandom_range(0, 9) == 0) gx = '1;
    if ($urandom_range(0, 9) == 0) gy = '1;
    if ($urandom_range(0, 99) < 85) begin
      row = mgse_pkg::ROW_W'($urandom_range(0, sh_size - 1));
      col = mgse_pkg::COL_W'($urandom_range(0, sh_size / 8 - 1));
    end else begin
      row = mgse_pkg::ROW_W'($urandom);
      col = mgse_pkg::COL_W'($urandom);
    end
    case ($urandom_range(0, 7))
      0: pat = 8'h00;
      1: pat = 8'hFF;
      default: pat = mgse_pkg::PAT_W'($urandom);
    endcase
    send_glyph(gx, gy, row, col, pat, produced);
  endtask

  task automatic test_random_phases();
    int n;
    logic [mgse_pkg::SCALE_W-1:0] sc;
    logic [mgse_pkg::PITCH_W-1:0] pitch;
    logic [mgse_pkg::SIZE_W-1:0] size;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 5))
        0: sc = 4'd8;
        1: sc = 4'd0;
        2: sc = mgse_pkg::SCALE_W'($urandom_range(9, 15));
        default: sc = mgse_pkg::SCALE_W'($urandom_range(1, 3));
      endcase
      pitch = ($urandom_range(0, 5) == 0) ? 12'($urandom) : 12'($urandom_range(1, 2048));
      size = mgse_pkg::SIZE_W'($urandom_range(8, 63));
      if (phase == 0) begin
        set_config(32'h0000_0000, 32'h0000_0000, 1'b0, 4'd1, 12'd1, 6'd8);
      end else if (phase == 1) begin
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 4'd8, 12'd2048, 6'd48);
      end else begin
        set_config($urandom, $urandom, 1'($urandom), sc, pitch, size);
      end
      if (phase == 5) begin
        quiet <= 1'b1;
      end
      for (int k = 0; k < 16; k++) begin
        send_random_glyph(n);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst || quiet) begin
      span_out.ready <= 1'b1;
    end else if (stall_left > 0) begin
      span_out.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      span_out.ready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      span_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : span_checker
    span_t want;
    if (!rst && span_out.valid && span_out.ready) begin
      spans_seen++;
      if (pending_spans.size() == 0) begin
        flag_mismatch("unexpected span address", 64'(span_out.span_address), '0);
      end else begin
        want = pending_spans.pop_front();
        if (span_out.span_address !== want.addr)
          flag_mismatch("span_address", 64'(span_out.span_address), 64'(want.addr));
        if (span_out.span_length !== want.len)
          flag_mismatch("span_length", 64'(span_out.span_length), 64'(want.len));
        if (span_out.pixel_color !== want.color)
          flag_mismatch("pixel_color", 64'(span_out.pixel_color), 64'(want.color));
        if (span_out.last !== want.last)
          flag_mismatch("last", 64'(span_out.last), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d spans outstanding", cycle_count,
               pending_spans.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= mgse_pkg::REG_FG_COLOR;
    cfg_data <= '0;
    glyph_in.valid <= 1'b0;
    glyph_in.glyph_x <= '0;
    glyph_in.glyph_y <= '0;
    glyph_in.glyph_row <= '0;
    glyph_in.byte_column <= '0;
    glyph_in.pattern <= '0;
    sh_fg = mgse_pkg::FG_RESET;
    sh_bg = mgse_pkg::BG_RESET;
    sh_opaque = 1'b0;
    sh_scale = mgse_pkg::SCALE_RESET;
    sh_pitch = mgse_pkg::PITCH_RESET;
    sh_size = mgse_pkg::SIZE_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_out_of_glyph();
    test_odd_settings();
    test_random_phases();
    settle();
    $display("Sent %0d glyph bytes under %0d register settings, checked %0d span transfers.",
             bytes_sent, settings_used, spans_seen);
    $display("Mismatches found: %0d", error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
